// ===== rtl/irph_pkg.sv =====
// ----------------------------------------------------------------------------
// irph_pkg
// Shared types, codes and helper functions for the peer handshake engine.
// ----------------------------------------------------------------------------
package irph_pkg;

   localparam int ID_BYTES   = 6;
   localparam int TIMER_BITS = 16;

   localparam int ID_W      = 48;
   localparam int CFG_TMR_W = 16;
   localparam int CHK_W     = 8;
   localparam int PKT_W     = 3;
   localparam int OP_W      = 2;
   localparam int CSR_AW    = 2;

   // bytes of an ID that take part in compares and checksums
   localparam int ID_BYTES_USED = (ID_BYTES < ID_W / 8) ? ID_BYTES : ID_W / 8;
   localparam logic [ID_W-1:0] ID_MASK = (ID_BYTES >= ID_W / 8) ? {ID_W{1'b1}} :
      ID_W'((64'd1 << (8 * ID_BYTES)) - 64'd1);

   // request opcodes
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_PKT   = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

   // packet types
   localparam logic [PKT_W-1:0] PK_REQ  = 3'd0;
   localparam logic [PKT_W-1:0] PK_ACC  = 3'd1;
   localparam logic [PKT_W-1:0] PK_DATA = 3'd2;
   localparam logic [PKT_W-1:0] PK_ACK  = 3'd3;
   localparam logic [PKT_W-1:0] PK_CANC = 3'd4;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_OWN_ID  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_DELAY   = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_WAIT = 3'd1,
      PH_SEND = 3'd2,
      PH_RECV = 3'd3,
      PH_DONE = 3'd4,
      PH_TOUT = 3'd5,
      PH_CANC = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_START = 2'd1,
      EV_PKT   = 2'd2,
      EV_TICK  = 2'd3
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type      kind;
      logic [PKT_W-1:0] ptype;
      logic [ID_W-1:0]  sender;
      logic             bad;
   } event_type;

   function automatic logic [CHK_W-1:0] xor_check(input logic [PKT_W-1:0] ptype,
                                                  input logic [ID_W-1:0]  id);
      logic [CHK_W-1:0] c;
      c = CHK_W'(ptype);
      for (int i = 0; i < ID_BYTES_USED; i++) begin
         c = c ^ id[8*i +: 8];
      end
      return c;
   endfunction

   // saturate to the counter width, never load zero
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_TMR_W-1:0] v);
      logic [TIMER_BITS-1:0] r;
      if (TIMER_BITS < CFG_TMR_W && (v >> TIMER_BITS) != '0) begin
         r = '1;
      end else begin
         r = TIMER_BITS'(v);
      end
      if (r == '0) begin
         r = TIMER_BITS'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/irph_front.sv =====
// ----------------------------------------------------------------------------
// irph_front
// Classifies incoming transactions and screens packet checksums.
// ----------------------------------------------------------------------------
module irph_front
   import irph_pkg::*;
(
   input  logic [OP_W-1:0]  op,
   input  logic [PKT_W-1:0] pkt_type,
   input  logic [ID_W-1:0]  pkt_sender,
   input  logic [CHK_W-1:0] pkt_check,
   output event_type        ev
);

   logic chk_ok;

   assign chk_ok = (xor_check(pkt_type, pkt_sender) == pkt_check);

   always_comb begin
      ev.ptype  = pkt_type;
      ev.sender = pkt_sender;
      ev.bad    = 1'b0;
      unique case (op)
         OP_START: ev.kind = EV_START;
         OP_PKT: begin
            // a corrupt packet only raises the flag
            ev.kind = chk_ok ? EV_PKT : EV_NONE;
            ev.bad  = !chk_ok;
         end
         OP_TICK: ev.kind = EV_TICK;
         default: ev.kind = EV_NONE;
      endcase
   end

endmodule

// ===== rtl/irph_fifo.sv =====
// ----------------------------------------------------------------------------
// irph_fifo
// Two-entry event queue between the classifier and the protocol engine.
// ----------------------------------------------------------------------------
module irph_fifo
   import irph_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output event_type pop_data
);

   event_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("event queue written while full");

endmodule

// ===== rtl/irph_back.sv =====
// ----------------------------------------------------------------------------
// irph_back
// Handshake protocol engine with step countdown and result register.
// ----------------------------------------------------------------------------
module irph_back
   import irph_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ID_W-1:0]      own_id,
   input  logic [CFG_TMR_W-1:0] exchange_timeout,
   input  logic [CFG_TMR_W-1:0] idle_delay,
   input  logic                 ev_valid,
   input  event_type            ev,
   output logic                 ev_pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 send_valid,
   output logic [PKT_W-1:0]     send_type,
   output logic [ID_W-1:0]      send_sender,
   output logic [CHK_W-1:0]     send_check,
   output logic [2:0]           proto_state,
   output logic                 check_bad,
   output logic                 sync_done,
   output logic [ID_W-1:0]      peer_out
);

   phase_type             phase_ff, phase_in;
   logic [ID_W-1:0]       peer_ff, peer_in;
   logic [TIMER_BITS-1:0] rem_ff, rem_in;
   logic [TIMER_BITS-1:0] rem_dec;

   logic                  ov_ff, ov_in;
   logic                  snd_ff, bad_ff, done_ff;
   logic [PKT_W-1:0]      stype_ff;
   logic [CHK_W-1:0]      schk_ff;
   logic [ID_W-1:0]       ssnd_ff, peer_o_ff;
   phase_type             state_o_ff;

   logic                  snd, done, active, match;
   logic [PKT_W-1:0]      stype;

   assign ev_pop  = ev_valid && (!ov_ff || out_ready);
   assign rem_dec = rem_ff - TIMER_BITS'(1);

   always_comb begin
      phase_in = phase_ff;
      peer_in  = peer_ff;
      rem_in   = rem_ff;
      snd      = 1'b0;
      stype    = PK_REQ;
      done     = 1'b0;
      active   = (phase_ff == PH_SEND) || (phase_ff == PH_RECV);
      match    = ((ev.sender & ID_MASK) == (peer_ff & ID_MASK));
      unique case (ev.kind)
         EV_START: begin
            if (phase_ff == PH_IDLE) begin
               peer_in  = '0;
               phase_in = PH_WAIT;
               rem_in   = timer_load(exchange_timeout);
               snd      = 1'b1;
               stype    = PK_REQ;
            end
         end
         EV_PKT: begin
            if (phase_ff == PH_WAIT || active) begin
               if (ev.ptype == PK_CANC) begin
                  if (active && match) begin
                     phase_in = PH_CANC;
                     rem_in   = timer_load(idle_delay);
                  end
               end else if (active && !match) begin
                  // stray packet from another node
               end else begin
                  unique case (phase_ff)
                     PH_WAIT: begin
                        if (ev.ptype == PK_REQ) begin
                           rem_in = timer_load(exchange_timeout);
                           // lower ID takes the receiver role
                           if ((own_id & ID_MASK) < (ev.sender & ID_MASK)) begin
                              peer_in  = ev.sender;
                              phase_in = PH_RECV;
                              snd      = 1'b1;
                              stype    = PK_ACC;
                           end
                        end else if (ev.ptype == PK_ACC) begin
                           peer_in  = ev.sender;
                           rem_in   = timer_load(exchange_timeout);
                           phase_in = PH_SEND;
                           snd      = 1'b1;
                           stype    = PK_DATA;
                        end
                     end
                     PH_SEND: begin
                        if (ev.ptype == PK_ACK) begin
                           phase_in = PH_DONE;
                           done     = 1'b1;
                           rem_in   = timer_load(idle_delay);
                        end else if (ev.ptype == PK_ACC) begin
                           rem_in = timer_load(exchange_timeout);
                           snd    = 1'b1;
                           stype  = PK_DATA;
                        end
                     end
                     PH_RECV: begin
                        if (ev.ptype == PK_DATA) begin
                           snd      = 1'b1;
                           stype    = PK_ACK;
                           phase_in = PH_DONE;
                           done     = 1'b1;
                           rem_in   = timer_load(idle_delay);
                        end else if (ev.ptype == PK_REQ) begin
                           rem_in = timer_load(exchange_timeout);
                           snd    = 1'b1;
                           stype  = PK_ACC;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         EV_TICK: begin
            if (rem_ff != '0) begin
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  if (phase_ff == PH_WAIT || active) begin
                     if (active) begin
                        snd   = 1'b1;
                        stype = PK_CANC;
                     end
                     phase_in = PH_TOUT;
                     rem_in   = timer_load(idle_delay);
                  end else if (phase_ff != PH_IDLE) begin
                     phase_in = PH_IDLE;
                     peer_in  = '0;
                  end
               end
            end
         end
         default: ;
      endcase
      ov_in = ev_pop || (ov_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         peer_ff  <= '0;
         rem_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         if (ev_pop) begin
            phase_ff <= phase_in;
            peer_ff  <= peer_in;
            rem_ff   <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop) begin
         snd_ff     <= snd;
         stype_ff   <= snd ? stype : '0;
         ssnd_ff    <= snd ? own_id : '0;
         schk_ff    <= snd ? xor_check(stype, own_id) : '0;
         state_o_ff <= phase_in;
         bad_ff     <= ev.bad;
         done_ff    <= done;
         peer_o_ff  <= peer_in;
      end
   end

   assign out_valid   = ov_ff;
   assign send_valid  = snd_ff;
   assign send_type   = stype_ff;
   assign send_sender = ssnd_ff;
   assign send_check  = schk_ff;
   assign proto_state = state_o_ff;
   assign check_bad   = bad_ff;
   assign sync_done   = done_ff;
   assign peer_out    = peer_o_ff;

   a_done_state: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && done_ff) |-> (state_o_ff == PH_DONE))
      else $error("completion pulse without completed state");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !snd_ff) |-> (stype_ff == '0 && ssnd_ff == '0 && schk_ff == '0))
      else $error("packet fields set with nothing to send");

   a_bad_is_inert: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && bad_ff) |-> (!snd_ff && !done_ff))
      else $error("dropped packet produced an action");

endmodule

// ===== rtl/ir_peer_handshake_fsm.sv =====
// ----------------------------------------------------------------------------
// ir_peer_handshake_fsm
// Two-party peer ID handshake engine with checksum screening and timeouts.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event per transaction: tuser selects start, received
//   packet or millisecond tick; tdata holds the packet fields.
//   rsp_* returns exactly one result per request: the packet to transmit
//   (if any), the protocol state, the bad-checksum flag, the completion
//   pulse and the current peer ID.
//   csr_* writes own_id, exchange_timeout and idle_delay; write only while
//   the block is idle.
// Timing:
//   Each request passes through the event queue to a registered result. One
//   request per cycle is sustained while rsp_tready is high; the protocol
//   engine then handles one event per cycle in a single compare-and-update step.
// Reset:
//   Synchronous; returns to idle with no peer, timer stopped and registers
//   at their defaults (own_id 0, timeout 1000, delay 500).
// Stalls:
//   While rsp_tready is low the result holds and up to two further requests
//   are queued; req_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module ir_peer_handshake_fsm
   import irph_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [ID_W-1:0]   csr_wdata,
   // request stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,  // pkt_type[2:0] pkt_sender[50:3] pkt_check[58:51]
   input  logic [OP_W-1:0]   req_tuser,  // op[1:0]
   // response stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [119:0]      rsp_tdata   // send_valid[0] send_type[3:1] send_sender[51:4]
                                         // send_check[59:52] proto_state[62:60]
                                         // check_bad[63] sync_done[64] peer_out[112:65]
);

   logic [ID_W-1:0]      own_id_ff;
   logic [CFG_TMR_W-1:0] timeout_ff;
   logic [CFG_TMR_W-1:0] delay_ff;

   event_type            ev_front, ev_q;
   logic                 q_full, q_not_empty, q_pop, push;

   logic                 send_valid, check_bad, sync_done;
   logic [PKT_W-1:0]     send_type;
   logic [ID_W-1:0]      send_sender, peer_out;
   logic [CHK_W-1:0]     send_check;
   logic [2:0]           proto_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff  <= '0;
         timeout_ff <= CFG_TMR_W'(1000);
         delay_ff   <= CFG_TMR_W'(500);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_OWN_ID:  own_id_ff  <= csr_wdata;
            CSR_TIMEOUT: timeout_ff <= csr_wdata[CFG_TMR_W-1:0];
            CSR_DELAY:   delay_ff   <= csr_wdata[CFG_TMR_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   irph_front u_front (
      .op         (req_tuser),
      .pkt_type   (req_tdata[2:0]),
      .pkt_sender (req_tdata[50:3]),
      .pkt_check  (req_tdata[58:51]),
      .ev         (ev_front)
   );

   irph_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (ev_front),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (ev_q)
   );

   irph_back u_back (
      .clock            (clock),
      .reset            (reset),
      .own_id           (own_id_ff),
      .exchange_timeout (timeout_ff),
      .idle_delay       (delay_ff),
      .ev_valid         (q_not_empty),
      .ev               (ev_q),
      .ev_pop           (q_pop),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .send_valid       (send_valid),
      .send_type        (send_type),
      .send_sender      (send_sender),
      .send_check       (send_check),
      .proto_state      (proto_state),
      .check_bad        (check_bad),
      .sync_done        (sync_done),
      .peer_out         (peer_out)
   );

   assign rsp_tdata = {7'd0, peer_out, sync_done, check_bad, proto_state,
                       send_check, send_sender, send_type, send_valid};

endmodule
